// File: design/bmht_pkg.sv
package bmht_pkg;

    // default number of slots in the storage
    localparam int TABLE_DEPTH_DEF = 32;

    // widths fixed by the interface
    localparam int SIZE_W   = 6;
    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 5;

    // reset value of the size register
    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 6'd32;

    // the active size never exceeds what the size register can hold
    localparam int SIZE_MAX = 63;

    // key times seven is three bits wider than the key
    localparam int PROD_W     = KEY_W + 3;
    localparam int PROD_CNT_W = 6;

    // operation codes
    localparam logic [OP_W-1:0] OP_GET_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD       = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP    = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage

// File: design/block_map_hash_table_unit.sv
// channel   | signals                              | transfer
// ----------+--------------------------------------+-------------------------------
// request   | start, op, vblock, new_value, busy   | clk edge with start & !busy
// result    | done, status, mapped_block, slot     | clk edge ending the done cycle
// config    | cfg_wen, cfg_wdata                   | clk edge with cfg_wen high
//
// a request runs from the accepting edge to the end of done: the bit-serial
// remainder of (vblock * 7) by the active size, then the probes, each a valid
// check and key/value memory read, then a key compare; a probe that meets an
// empty slot ends after the valid check. a zero table size skips both.
// busy is high from the accepting edge until done; done lasts one cycle and
// the receiver cannot stall it. reset clears the valid bits, the allocation
// counter and sets table_size to 32.
module block_map_hash_table_unit #(
    parameter int TABLE_DEPTH = bmht_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [bmht_pkg::OP_W-1:0]      op,
    input  logic [bmht_pkg::KEY_W-1:0]     vblock,
    input  logic [bmht_pkg::VAL_W-1:0]     new_value,
    output logic                           done,
    output logic [bmht_pkg::STATUS_W-1:0]  status,
    output logic [bmht_pkg::VAL_W-1:0]     mapped_block,
    output logic [bmht_pkg::SLOT_W-1:0]    slot,
    input  logic                           cfg_wen,
    input  logic [bmht_pkg::SIZE_W-1:0]    cfg_wdata
);

    // only slots below the largest possible table size are ever reached
    localparam int SLOTS = (TABLE_DEPTH < bmht_pkg::SIZE_MAX) ? TABLE_DEPTH
                                                              : bmht_pkg::SIZE_MAX;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [bmht_pkg::PROD_CNT_W-1:0] LAST_STEP =
        bmht_pkg::PROD_CNT_W'(bmht_pkg::PROD_W - 1);
    localparam logic [bmht_pkg::SIZE_W-1:0] SLOTS_SZ = bmht_pkg::SIZE_W'(SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_PADDR,
        S_PCHK,
        S_FINISH
    } state_t;

    state_t                            state_reg, state_next;
    logic [bmht_pkg::SIZE_W-1:0]       table_size_reg, table_size_next;
    logic [CNT_W-1:0]                  size_reg, size_next;
    logic [bmht_pkg::PROD_W-1:0]       prod_reg, prod_next;
    logic [CNT_W-1:0]                  rem_reg, rem_next;
    logic [bmht_pkg::PROD_CNT_W-1:0]   step_reg, step_next;
    logic [IDX_W-1:0]                  idx_reg, idx_next;
    logic [CNT_W-1:0]                  tries_reg, tries_next;
    logic [bmht_pkg::OP_W-1:0]         op_reg, op_next;
    logic [bmht_pkg::KEY_W-1:0]        key_reg, key_next;
    logic [bmht_pkg::VAL_W-1:0]        val_reg, val_next;
    logic [bmht_pkg::STATUS_W-1:0]     st_reg, st_next;
    logic [SLOTS-1:0]                  valid_reg, valid_next;
    logic [bmht_pkg::VAL_W-1:0]        next_free_reg, next_free_next;
    logic                              done_reg, done_next;
    logic [bmht_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [bmht_pkg::VAL_W-1:0]        mapped_reg, mapped_next;
    logic [bmht_pkg::SLOT_W-1:0]       slot_reg, slot_next;

    // key and value storage, registered read
    logic [bmht_pkg::KEY_W-1:0]        key_mem [SLOTS];
    logic [bmht_pkg::VAL_W-1:0]        val_mem [SLOTS];
    logic [bmht_pkg::KEY_W-1:0]        rd_key_reg;
    logic [bmht_pkg::VAL_W-1:0]        rd_val_reg;
    logic                              wr_en;
    logic [bmht_pkg::VAL_W-1:0]        wr_val;

    // shared remainder step and probe index helpers
    logic [CNT_W:0]                    trial;
    logic [CNT_W:0]                    trial_sub;
    logic [CNT_W-1:0]                  idx_inc;

    assign trial     = {rem_reg, prod_reg[bmht_pkg::PROD_W-1]};
    assign trial_sub = trial - {1'b0, size_reg};
    assign idx_inc   = CNT_W'(idx_reg) + CNT_W'(1);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        table_size_next = table_size_reg;
        size_next       = size_reg;
        prod_next       = prod_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        idx_next        = idx_reg;
        tries_next      = tries_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        st_next         = st_reg;
        valid_next      = valid_reg;
        next_free_next  = next_free_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        mapped_next     = mapped_reg;
        slot_next       = slot_reg;
        wr_en           = 1'b0;
        wr_val          = val_reg;

        if (cfg_wen)
        begin
            table_size_next = cfg_wdata;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op;
                    key_next   = vblock;
                    val_next   = new_value;
                    prod_next  = ({3'b000, vblock} << 3) - {3'b000, vblock};
                    rem_next   = '0;
                    step_next  = '0;
                    if (table_size_reg > SLOTS_SZ)
                    begin
                        size_next = CNT_W'(SLOTS);
                    end
                    else
                    begin
                        size_next = CNT_W'(table_size_reg);
                    end
                    if (table_size_reg == '0)
                    begin
                        st_next    = bmht_pkg::ST_FULL;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end

            // one remainder bit per cycle, msb of the product first
            S_HASH:
            begin
                prod_next = prod_reg << 1;
                if (trial >= {1'b0, size_reg})
                begin
                    rem_next = CNT_W'(trial_sub);
                end
                else
                begin
                    rem_next = CNT_W'(trial);
                end
                step_next = step_reg + bmht_pkg::PROD_CNT_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    idx_next   = IDX_W'(rem_next);
                    tries_next = '0;
                    state_next = S_PADDR;
                end
            end

            // an empty slot ends the probe, else the memory read is under way
            S_PADDR:
            begin
                if (!valid_reg[idx_reg])
                begin
                    st_next    = bmht_pkg::ST_FREE;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_PCHK;
                end
            end

            // key compare, full once every slot is tried, else step to the next slot with wrap
            S_PCHK:
            begin
                if (rd_key_reg == key_reg)
                begin
                    st_next    = bmht_pkg::ST_OK;
                    state_next = S_FINISH;
                end
                else if (tries_reg + CNT_W'(1) == size_reg)
                begin
                    st_next    = bmht_pkg::ST_FULL;
                    state_next = S_FINISH;
                end
                else
                begin
                    tries_next = tries_reg + CNT_W'(1);
                    if (idx_inc == size_reg)
                    begin
                        idx_next = '0;
                    end
                    else
                    begin
                        idx_next = IDX_W'(idx_inc);
                    end
                    state_next = S_PADDR;
                end
            end

            // result and table update
            S_FINISH:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                slot_next  = bmht_pkg::SLOT_W'(idx_reg);
                if (st_reg == bmht_pkg::ST_FULL)
                begin
                    status_next = bmht_pkg::ST_FULL;
                    mapped_next = '0;
                    slot_next   = '0;
                end
                else if (op_reg == bmht_pkg::OP_GET_ALLOC)
                begin
                    status_next = bmht_pkg::ST_OK;
                    if (st_reg == bmht_pkg::ST_OK)
                    begin
                        mapped_next = rd_val_reg;
                    end
                    else
                    begin
                        mapped_next         = next_free_reg;
                        next_free_next      = next_free_reg + bmht_pkg::VAL_W'(1);
                        valid_next[idx_reg] = 1'b1;
                        wr_en               = 1'b1;
                        wr_val              = next_free_reg;
                    end
                end
                else if (op_reg == bmht_pkg::OP_ADD)
                begin
                    status_next         = bmht_pkg::ST_OK;
                    mapped_next         = val_reg;
                    valid_next[idx_reg] = 1'b1;
                    wr_en               = 1'b1;
                    wr_val              = val_reg;
                end
                else
                begin
                    status_next = st_reg;
                    if (st_reg == bmht_pkg::ST_OK)
                    begin
                        mapped_next = rd_val_reg;
                    end
                    else
                    begin
                        mapped_next = '0;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            table_size_reg <= bmht_pkg::TABLE_SIZE_RST;
            valid_reg      <= '0;
            next_free_reg  <= '0;
            done_reg       <= 1'b0;
            status_reg     <= '0;
            mapped_reg     <= '0;
            slot_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            table_size_reg <= table_size_next;
            valid_reg      <= valid_next;
            next_free_reg  <= next_free_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
            mapped_reg     <= mapped_next;
            slot_reg       <= slot_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        size_reg   <= size_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        idx_reg    <= idx_next;
        tries_reg  <= tries_next;
        op_reg     <= op_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        st_reg     <= st_next;
    end

    // key and value memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[idx_reg] <= key_reg;
            val_mem[idx_reg] <= wr_val;
        end
        rd_key_reg <= key_mem[idx_reg];
        rd_val_reg <= val_mem[idx_reg];
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign mapped_block = mapped_reg;
    assign slot         = slot_reg;

endmodule

// File: test/tb_block_map_hash_table_unit.sv
`timescale 1ns / 1ps

module tb_block_map_hash_table_unit;

    localparam int DEPTH        = bmht_pkg::TABLE_DEPTH_DEF;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_REQS  = 1000;
    localparam int MAX_REPORTS  = 10;
    // longest request: setup, serial remainder and every probe, plus margin
    localparam int DRAIN_CYCLES = 2 + 35 + 2 * DEPTH + 20;
    localparam int TIMEOUT_NS   = 5_000_000;
    // sender never idles while between CALM_FROM and CALM_TO requests have gone out
    localparam int CALM_FROM    = 300;
    localparam int CALM_TO      = 450;

    localparam longint unsigned HASH_MULT = 7;

    // op code the block has no meaning for, handled as a lookup
    localparam logic [bmht_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum logic [1:0] {WK_REQ, WK_CFG, WK_PAUSE} work_kind_t;

    typedef struct {
        work_kind_t                   kind;
        logic [bmht_pkg::OP_W-1:0]    op;
        logic [bmht_pkg::KEY_W-1:0]   key;
        logic [bmht_pkg::VAL_W-1:0]   val;
        logic [bmht_pkg::SIZE_W-1:0]  size;
    } work_item_t;

    typedef struct {
        logic [bmht_pkg::STATUS_W-1:0] status;
        logic [bmht_pkg::VAL_W-1:0]    mapped;
        logic [bmht_pkg::SLOT_W-1:0]   slot;
    } map_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [bmht_pkg::OP_W-1:0]     op = bmht_pkg::OP_LOOKUP;
    logic [bmht_pkg::KEY_W-1:0]    vblock = '0;
    logic [bmht_pkg::VAL_W-1:0]    new_value = '0;
    logic                          done;
    logic [bmht_pkg::STATUS_W-1:0] status;
    logic [bmht_pkg::VAL_W-1:0]    mapped_block;
    logic [bmht_pkg::SLOT_W-1:0]   slot;
    logic                          cfg_wen = 1'b0;
    logic [bmht_pkg::SIZE_W-1:0]   cfg_wdata = '0;

    // stimulus waiting for the driver and results waiting for the block
    work_item_t  block_reqs[$];
    map_result_t expected_maps[$];

    logic req_taken = 1'b0;
    int   reqs_sent = 0;
    int   err_count = 0;

    // shadow copy of the mapping table
    logic [bmht_pkg::SIZE_W-1:0] tbl_size = bmht_pkg::TABLE_SIZE_RST;
    logic                        tbl_valid [DEPTH] = '{default: 1'b0};
    logic [bmht_pkg::KEY_W-1:0]  tbl_key   [DEPTH];
    logic [bmht_pkg::VAL_W-1:0]  tbl_value [DEPTH];
    logic [bmht_pkg::VAL_W-1:0]  alloc_next = '0;

    block_map_hash_table_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .vblock       (vblock),
        .new_value    (new_value),
        .done         (done),
        .status       (status),
        .mapped_block (mapped_block),
        .slot         (slot),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // probe the shadow table and apply the request to it
    function automatic map_result_t resolve_block(input logic [bmht_pkg::OP_W-1:0] rop,
                                                  input logic [bmht_pkg::KEY_W-1:0] key,
                                                  input logic [bmht_pkg::VAL_W-1:0] val);
        map_result_t     r;
        int unsigned     n;
        int unsigned     idx;
        int unsigned     tries;
        longint unsigned prod;
        logic            found;
        r.status = bmht_pkg::ST_FULL;
        r.mapped = '0;
        r.slot   = '0;
        n = (tbl_size > DEPTH) ? DEPTH : tbl_size;
        if (n == 0)
            return r;
        prod  = 64'(key) * HASH_MULT;
        idx   = int'(prod % n);
        tries = 0;
        while (tbl_valid[idx] && tries < n && tbl_key[idx] != key)
        begin
            idx = (idx + 1) % n;
            tries++;
        end
        if (tries >= n)
            return r;
        found  = tbl_valid[idx];
        r.slot = bmht_pkg::SLOT_W'(idx);
        case (rop)
            bmht_pkg::OP_GET_ALLOC:
            begin
                if (found)
                    r.mapped = tbl_value[idx];
                else
                begin
                    r.mapped       = alloc_next;
                    alloc_next     = alloc_next + bmht_pkg::VAL_W'(1);
                    tbl_valid[idx] = 1'b1;
                    tbl_key[idx]   = key;
                    tbl_value[idx] = r.mapped;
                end
                r.status = bmht_pkg::ST_OK;
            end
            bmht_pkg::OP_ADD:
            begin
                tbl_valid[idx] = 1'b1;
                tbl_key[idx]   = key;
                tbl_value[idx] = val;
                r.mapped       = val;
                r.status       = bmht_pkg::ST_OK;
            end
            default:
            begin
                r.status = found ? bmht_pkg::ST_OK : bmht_pkg::ST_FREE;
                r.mapped = found ? tbl_value[idx] : '0;
            end
        endcase
        return r;
    endfunction

    task automatic add_req(input logic [bmht_pkg::OP_W-1:0] rop,
                           input logic [bmht_pkg::KEY_W-1:0] key,
                           input logic [bmht_pkg::VAL_W-1:0] val);
        work_item_t w;
        w.kind = WK_REQ;
        w.op   = rop;
        w.key  = key;
        w.val  = val;
        w.size = '0;
        block_reqs.push_back(w);
    endtask

    task automatic add_cfg(input logic [bmht_pkg::SIZE_W-1:0] size);
        work_item_t w;
        w.kind = WK_CFG;
        w.op   = bmht_pkg::OP_LOOKUP;
        w.key  = '0;
        w.val  = '0;
        w.size = size;
        block_reqs.push_back(w);
    endtask

    task automatic add_pause();
        work_item_t w;
        w.kind = WK_PAUSE;
        w.op   = bmht_pkg::OP_LOOKUP;
        w.key  = '0;
        w.val  = '0;
        w.size = '0;
        block_reqs.push_back(w);
    endtask

    // driver: requests, register writes and pauses, changed on the falling edge
    always @(negedge clk)
    begin : driver
        work_item_t nxt;
        logic       go;
        logic       wen;
        go  = start && !req_taken;
        wen = 1'b0;
        if (rst_n && !go && block_reqs.size() != 0)
        begin
            nxt = block_reqs[0];
            if (nxt.kind == WK_REQ)
            begin
                if ((reqs_sent >= CALM_FROM && reqs_sent < CALM_TO)
                    || $urandom_range(99) >= 7)
                begin
                    void'(block_reqs.pop_front());
                    go = 1'b1;
                    op        <= nxt.op;
                    vblock    <= nxt.key;
                    new_value <= nxt.val;
                    reqs_sent <= reqs_sent + 1;
                end
            end
            // register writes and pauses wait until the block has drained
            else if (expected_maps.size() == 0 && !busy)
            begin
                void'(block_reqs.pop_front());
                if (nxt.kind == WK_CFG)
                begin
                    wen = 1'b1;
                    cfg_wdata <= nxt.size;
                end
            end
        end
        start   <= go;
        cfg_wen <= wen;
    end

    // monitor: check each result transfer, then predict the accepted request
    always @(posedge clk)
    begin : monitor
        map_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_maps.size() == 0)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: unexpected result status %0d mapped %h slot %0d",
                                 $realtime, status, mapped_block, slot);
                end
                else
                begin
                    want = expected_maps.pop_front();
                    if (status !== want.status || mapped_block !== want.mapped
                        || slot !== want.slot)
                    begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                        begin
                            $write("%0t: mismatch expected status %0d mapped %h slot %0d",
                                   $realtime, want.status, want.mapped, want.slot);
                            $display(", got status %0d mapped %h slot %0d",
                                     status, mapped_block, slot);
                        end
                    end
                end
            end
            if (cfg_wen)
                tbl_size = cfg_wdata;
            if (start && !busy)
                expected_maps.push_back(resolve_block(op, vblock, new_value));
        end
        req_taken <= rst_n && start && !busy;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [bmht_pkg::KEY_W-1:0]  pool [8];
        logic [bmht_pkg::KEY_W-1:0]  key;
        logic [bmht_pkg::OP_W-1:0]   rop;
        logic [bmht_pkg::SIZE_W-1:0] size;
        int                          n_random;
        int                          len;
        int                          pick;

        // directed: empty table, allocation, overwrite, collisions, extremes
        add_req(bmht_pkg::OP_LOOKUP,    32'h0000_0000, 32'h0000_0000);
        add_req(bmht_pkg::OP_GET_ALLOC, 32'h0000_0000, 32'hFFFF_FFFF);
        add_req(bmht_pkg::OP_GET_ALLOC, 32'h0000_0000, 32'h0000_0000);
        add_req(bmht_pkg::OP_ADD,       32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(bmht_pkg::OP_LOOKUP,    32'hFFFF_FFFF, 32'h0000_0000);
        add_req(bmht_pkg::OP_ADD,       32'h0000_0000, 32'hAAAA_5555);
        add_req(OP_UNUSED,              32'h0000_0000, 32'h5555_AAAA);
        add_req(bmht_pkg::OP_GET_ALLOC, 32'h0000_0020, 32'h0000_0000);
        add_req(bmht_pkg::OP_LOOKUP,    32'h0000_0040, 32'h0000_0000);
        add_req(bmht_pkg::OP_GET_ALLOC, 32'h8000_0000, 32'h0000_0000);
        // zero size answers full for every op
        add_cfg(6'd0);
        add_req(bmht_pkg::OP_GET_ALLOC, 32'h0000_0005, 32'h0000_0000);
        add_req(bmht_pkg::OP_ADD,       32'h0000_0005, 32'h1234_5678);
        add_req(bmht_pkg::OP_LOOKUP,    32'h0000_0005, 32'h0000_0000);
        // size above depth is clamped
        add_cfg(6'd63);
        add_req(bmht_pkg::OP_LOOKUP,    32'h0000_0020, 32'h0000_0000);
        // one slot: other keys find the table full, shrunk slots are ignored
        add_cfg(6'd1);
        add_req(bmht_pkg::OP_LOOKUP,    32'h0000_0000, 32'h0000_0000);
        add_req(bmht_pkg::OP_GET_ALLOC, 32'h0000_0007, 32'h0000_0000);
        add_req(bmht_pkg::OP_LOOKUP,    32'h0000_0020, 32'h0000_0000);
        add_pause();
        add_cfg(6'd3);
        add_req(bmht_pkg::OP_ADD,       32'h0000_0001, 32'h0000_0000);
        add_req(bmht_pkg::OP_LOOKUP,    32'h8000_0000, 32'h0000_0000);
        add_cfg(6'd32);
        add_req(bmht_pkg::OP_ADD,       32'h0000_0020, 32'h1234_5678);

        // random phases, each under its own table size, with a pool of reused keys
        n_random = 0;
        while (n_random < RANDOM_REQS)
        begin
            pick = $urandom_range(15);
            if (pick == 0)
                size = '0;
            else if (pick == 1)
                size = bmht_pkg::SIZE_W'($urandom_range(bmht_pkg::SIZE_MAX, DEPTH + 1));
            else if (pick == 2)
                size = bmht_pkg::SIZE_W'(DEPTH);
            else if (pick == 3)
                size = bmht_pkg::SIZE_W'($urandom_range(DEPTH - 1, 13));
            else
                size = bmht_pkg::SIZE_W'($urandom_range(12, 1));
            add_cfg(size);
            foreach (pool[i])
                pool[i] = $urandom;
            len = $urandom_range(80, 20);
            for (int k = 0; k < len; k++)
            begin
                if (k == len / 2 && $urandom_range(3) == 0)
                    add_pause();
                pick = $urandom_range(19);
                if (pick < 7)
                    rop = bmht_pkg::OP_GET_ALLOC;
                else if (pick < 12)
                    rop = bmht_pkg::OP_ADD;
                else if (pick < 18)
                    rop = bmht_pkg::OP_LOOKUP;
                else
                    rop = OP_UNUSED;
                key = ($urandom_range(9) < 7) ? pool[$urandom_range(7)] : $urandom;
                add_req(rop, key, $urandom);
                n_random++;
            end
        end

        // reset, then let the driver work through the list
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (block_reqs.size() != 0 || start || expected_maps.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (err_count == 0 && expected_maps.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
design/bmht_pkg.sv
design/block_map_hash_table_unit.sv
test/tb_block_map_hash_table_unit.sv
